// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset
`define FFA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ffa_pkg.sv
// Types and constants of the first-fit frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  localparam int MAX_REGIONS       = 4;
  localparam int FRAMES_PER_REGION = 1024;
  localparam int FRAME_SHIFT       = 12;

  localparam int REG_W  = 2;
  localparam int FRM_W  = 10;
  localparam int LEN_W  = 11;
  localparam int SIZE_W = 23;
  localparam int ADDR_W = REG_W + FRM_W;
  localparam int TOTAL_FRAMES = MAX_REGIONS * FRAMES_PER_REGION;
  localparam int BYTES_W = 32;
  localparam int RAW_W   = BYTES_W + 1 - FRAME_SHIFT;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] byte_count;
    logic [1:0]  free_region;
    logic [9:0]  free_frame;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  got_region;
    logic [9:0]  got_frame;
    logic [10:0] frame_total;
    logic [22:0] data_size;
  } out_t;

  typedef enum logic [1:0] {
    OP_FAIL  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] frames;
    logic [REG_W-1:0] region;
    logic [FRM_W-1:0] frame;
  } job_t;

  typedef logic [MAX_REGIONS-1:0][LEN_W-1:0] len_vec_t;

endpackage
`default_nettype wire

// File: sv/ffa_front.sv
// Front end: accept items and classify them into jobs for the queue.
`timescale 1ns / 1ps
`default_nettype none
module ffa_front (
  input  wire logic         start,
  input  wire logic         busy,
  input  wire ffa_pkg::in_t in_data,
  output logic              push,
  output ffa_pkg::job_t     job
);

  logic [ffa_pkg::BYTES_W:0]    sum;
  logic [ffa_pkg::RAW_W-1:0]    frames_raw;

  assign push       = start && !busy;
  assign sum        = {1'b0, in_data.byte_count}
                    + (ffa_pkg::BYTES_W+1)'((1 << ffa_pkg::FRAME_SHIFT) - 1);
  assign frames_raw = sum[ffa_pkg::BYTES_W:ffa_pkg::FRAME_SHIFT];

  always_comb begin
    job.frames = frames_raw[ffa_pkg::LEN_W-1:0];
    job.region = in_data.free_region;
    job.frame  = in_data.free_frame;
    if (in_data.cmd == ffa_pkg::CMD_FREE) begin
      job.op = ffa_pkg::OP_FREE;
    end else if (frames_raw == '0 ||
                 frames_raw > ffa_pkg::RAW_W'(ffa_pkg::FRAMES_PER_REGION)) begin
      job.op = ffa_pkg::OP_FAIL;
    end else begin
      job.op = ffa_pkg::OP_ALLOC;
    end
  end

endmodule
`default_nettype wire

// File: sv/ffa_queue.sv
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module ffa_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ffa_pkg::job_t din,
  input  wire logic          pop,
  output ffa_pkg::job_t      dout,
  output logic               full,
  output logic               empty
);

  ffa_pkg::job_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = !wp_r;
    end
    if (pop) begin
      rp_nxt = !rp_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// File: sv/ffa_back.sv
// Back end: frame stores, first-fit scan, run marking and release.
`timescale 1ns / 1ps
`default_nettype none
module ffa_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire ffa_pkg::job_t     q_job,
  input  wire ffa_pkg::len_vec_t region_len,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  output ffa_pkg::out_t          out_data
);

  localparam int LW = ffa_pkg::LEN_W;
  localparam int FW = ffa_pkg::FRM_W;
  localparam int RW = ffa_pkg::REG_W;
  localparam int AW = ffa_pkg::ADDR_W;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_MARK     = 7'b0001000,
    ST_FREE_RD  = 7'b0010000,
    ST_FREE_LD  = 7'b0100000,
    ST_FREE_CLR = 7'b1000000
  } state_t;

  state_t        st_r, st_nxt;
  ffa_pkg::job_t job_r, job_nxt;
  logic [RW-1:0] reg_r, reg_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic          pend_r, pend_nxt;
  logic [FW-1:0] pend_j_r, pend_j_nxt;
  logic [LW-1:0] avail_r, avail_nxt;
  logic [FW-1:0] start_r, start_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] tot_r, tot_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  ffa_pkg::out_t out_r, out_nxt;

  logic          busy_mem [ffa_pkg::TOTAL_FRAMES];
  logic [LW-1:0] run_mem  [ffa_pkg::TOTAL_FRAMES];
  logic          busy_rd;
  logic [LW-1:0] run_rd;
  logic          b_we, b_wd;
  logic [AW-1:0] b_wa, b_ra;
  logic          r_we;
  logic [LW-1:0] r_wd;
  logic [AW-1:0] r_wa, r_ra;

  logic [LW-1:0] len_raw, len_c, avail_inc, cap, start_w;
  logic          fits;

  assign len_raw   = region_len[reg_r];
  assign len_c     = (len_raw > LW'(ffa_pkg::FRAMES_PER_REGION))
                   ? LW'(ffa_pkg::FRAMES_PER_REGION) : len_raw;
  assign fits      = job_r.frames <= len_c;
  assign avail_inc = avail_r + LW'(1);
  assign start_w   = {1'b0, pend_j_r} + LW'(1) - job_r.frames;
  assign cap       = LW'(ffa_pkg::FRAMES_PER_REGION) - {1'b0, job_r.frame};

  assign clearing  = st_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt        = st_r;
    job_nxt       = job_r;
    reg_nxt       = reg_r;
    j_nxt         = j_r;
    pend_nxt      = 1'b0;
    pend_j_nxt    = pend_j_r;
    avail_nxt     = avail_r;
    start_nxt     = start_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    tot_nxt       = tot_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    b_we          = 1'b0;
    b_wd          = 1'b0;
    b_wa          = {reg_r, k_r[FW-1:0]};
    b_ra          = {reg_r, j_r[FW-1:0]};
    r_we          = 1'b0;
    r_wd          = '0;
    r_wa          = {job_r.region, job_r.frame};
    r_ra          = {job_r.region, job_r.frame};
    case (st_r)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_wa    = clr_r;
        r_we    = 1'b1;
        r_wa    = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          reg_nxt   = '0;
          j_nxt     = '0;
          avail_nxt = '0;
          case (q_job.op)
            ffa_pkg::OP_ALLOC: st_nxt = ST_SCAN;
            ffa_pkg::OP_FREE:  st_nxt = ST_FREE_RD;
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_r && !busy_rd && avail_inc == job_r.frames) begin
          start_nxt = start_w[FW-1:0];
          k_nxt     = start_w;
          rem_nxt   = job_r.frames;
          r_we      = 1'b1;
          r_wa      = {reg_r, start_w[FW-1:0]};
          r_wd      = job_r.frames;
          st_nxt    = ST_MARK;
        end else begin
          if (pend_r) begin
            avail_nxt = busy_rd ? '0 : avail_inc;
          end
          if (fits && j_r < len_c) begin
            pend_nxt   = 1'b1;
            pend_j_nxt = j_r[FW-1:0];
            j_nxt      = j_r + LW'(1);
          end else if (reg_r == RW'(ffa_pkg::MAX_REGIONS - 1)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            st_nxt        = ST_IDLE;
          end else begin
            reg_nxt   = reg_r + RW'(1);
            j_nxt     = '0;
            avail_nxt = '0;
          end
        end
      end
      ST_MARK: begin
        b_we    = 1'b1;
        b_wd    = 1'b1;
        k_nxt   = k_r + LW'(1);
        rem_nxt = rem_r - LW'(1);
        if (rem_r == LW'(1)) begin
          out_valid_nxt       = 1'b1;
          out_nxt.ok          = 1'b1;
          out_nxt.got_region  = reg_r;
          out_nxt.got_frame   = start_r;
          out_nxt.frame_total = job_r.frames;
          out_nxt.data_size   = {job_r.frames, {ffa_pkg::FRAME_SHIFT{1'b0}}};
          st_nxt              = ST_IDLE;
        end
      end
      ST_FREE_RD: begin
        st_nxt = ST_FREE_LD;
      end
      ST_FREE_LD: begin
        r_we    = 1'b1;
        tot_nxt = run_rd;
        rem_nxt = (run_rd < cap) ? run_rd : cap;
        k_nxt   = {1'b0, job_r.frame};
        reg_nxt = job_r.region;
        if (run_rd == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          st_nxt        = ST_IDLE;
        end else begin
          st_nxt = ST_FREE_CLR;
        end
      end
      ST_FREE_CLR: begin
        b_we    = 1'b1;
        k_nxt   = k_r + LW'(1);
        rem_nxt = rem_r - LW'(1);
        if (rem_r == LW'(1)) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.ok          = 1'b1;
          out_nxt.frame_total = tot_r;
          st_nxt              = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    reg_r    <= reg_nxt;
    j_r      <= j_nxt;
    pend_j_r <= pend_j_nxt;
    avail_r  <= avail_nxt;
    start_r  <= start_nxt;
    k_r      <= k_nxt;
    rem_r    <= rem_nxt;
    tot_r    <= tot_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      busy_mem[b_wa] <= b_wd;
    end
    busy_rd <= busy_mem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      run_mem[r_wa] <= r_wd;
    end
    run_rd <= run_mem[r_ra];
  end

endmodule
`default_nettype wire

// File: sv/first_fit_frame_allocator.sv
// Top level of the first-fit page-frame allocator.
// Usage:
//   Input: drive start with in_data; the item is taken at a clock edge where
//   start is high and busy is low. cmd selects allocate or free.
//   Config: cfg_valid/cfg_ready write region lengths (cfg_index 0..3); write
//   only while the block is idle. cfg_ready is always high.
//   Result: one item per input, shown for one cycle with out_valid high.
//   The receiver cannot stall; every result must be taken when shown.
// Operation:
//   allocate: the scan walks the busy-bit memory one frame per cycle across
//   regions in order, then marks the rounded frame count of frames busy.
//   free: releases the frames of the run, one busy bit cleared per cycle.
//   failed classification (zero bytes, oversize): answered without a scan.
//   Items run one at a time in the back end; a two-entry queue takes
//   further items until it fills, then busy rises.
// Reset: clears the region lengths, then sweeps all 4096 entries of both
//   frame memories, one entry per cycle, with busy held high.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_frame_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ffa_pkg::in_t                in_data,
  output logic                             out_valid,
  output ffa_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ffa_pkg::REG_W-1:0]   cfg_index,
  input  wire logic [ffa_pkg::LEN_W-1:0]   cfg_data
);

  ffa_pkg::len_vec_t region_len_r;
  ffa_pkg::job_t     f_job, q_job;
  logic              push, pop, q_full, q_empty, clearing;

  assign cfg_ready = 1'b1;
  assign busy      = q_full || clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      region_len_r[cfg_index] <= cfg_data;
    end
  end

  ffa_front u_front (
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .push    (push),
    .job     (f_job)
  );

  ffa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_job),
    .pop   (pop),
    .dout  (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  ffa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .region_len (region_len_r),
    .q_pop      (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: sv/ffa_checker.sv
// Port-level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ffa_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire ffa_pkg::out_t out_data
);

  `FFA_ASSERT_RST(a_reset_busy, !rst_n, busy, "busy low right after reset")
  `FFA_ASSERT_IMP(a_ok_total, out_valid && out_data.ok, out_data.frame_total != '0, "ok item with no frames")
  `FFA_ASSERT_IMP(a_fail_zero, out_valid && !out_data.ok, out_data == '0, "failed item has fields set")
  `FFA_ASSERT_IMP(a_size_match, out_valid && out_data.data_size != '0, out_data.data_size[11:0] == '0 && out_data.data_size[22:12] == out_data.frame_total, "size disagrees with frames")

endmodule

bind first_fit_frame_allocator ffa_checker u_ffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
